/* design/tcwq_pkg.sv */
package tcwq_pkg;

  // Scheduler FIFOs
  localparam int QUEUE_DEPTH = 16;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int ID_W    = 16;
  localparam int BURST_W = 4;

  localparam logic [BURST_W-1:0] BURST_RESET = 4'd2;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_PRIORITY_BURST = 1'b0;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] entry_id;
    logic            is_priority;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] served_id;
    logic            served_priority;
  } res_t;

endpackage

/* design/tcwq_ram.sv */
module tcwq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tcwq_front.sv */
module tcwq_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic                            op_i,
  input  logic [tcwq_pkg::ID_W-1:0]       entry_id_i,
  input  logic                            is_priority_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output tcwq_pkg::cmd_t                  cmd_o
);

  tcwq_pkg::cmd_t                      slot_q [tcwq_pkg::CMDQ_DEPTH];
  logic [tcwq_pkg::CMDQ_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tcwq_pkg::CMDQ_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tcwq_pkg::CMDQ_CNT_W-1:0]     cnt_q, cnt_d;
  logic                                wr_en, rd_en;
  tcwq_pkg::cmd_t                      cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in.op          = op_i ? tcwq_pkg::OP_SERVE : tcwq_pkg::OP_ENQUEUE;
    cmd_in.entry_id    = entry_id_i;
    cmd_in.is_priority = is_priority_i;
  end

  assign full_o      = (cnt_q == tcwq_pkg::CMDQ_CNT_W'(tcwq_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == tcwq_pkg::CMDQ_PTR_W'(tcwq_pkg::CMDQ_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == tcwq_pkg::CMDQ_PTR_W'(tcwq_pkg::CMDQ_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* design/tcwq_back.sv */
module tcwq_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tcwq_pkg::BURST_W-1:0]    burst_limit_i,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  tcwq_pkg::cmd_t                  cmd_i,
  output logic                            res_valid_o,
  input  logic                            res_pop_i,
  output tcwq_pkg::res_t                  res_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  localparam logic [tcwq_pkg::Q_CNT_W-1:0] CNT_FULL =
    tcwq_pkg::Q_CNT_W'(tcwq_pkg::QUEUE_DEPTH);

  function automatic logic [tcwq_pkg::Q_PTR_W-1:0] ptr_next(
    input logic [tcwq_pkg::Q_PTR_W-1:0] ptr
  );
    ptr_next = (ptr == tcwq_pkg::Q_PTR_W'(tcwq_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  logic                                state_q, state_d;
  logic                                src_prio_q, src_prio_d;
  logic [tcwq_pkg::Q_PTR_W-1:0]        p_head_q, p_head_d, p_tail_q, p_tail_d;
  logic [tcwq_pkg::Q_PTR_W-1:0]        n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [tcwq_pkg::Q_CNT_W-1:0]        p_cnt_q, p_cnt_d, n_cnt_q, n_cnt_d;
  logic [tcwq_pkg::BURST_W-1:0]        burst_q, burst_d;
  logic                                res_valid_q, res_valid_d;
  tcwq_pkg::res_t                      res_q, res_d;

  logic                                take;
  logic                                p_empty, n_empty, p_full, n_full;
  logic                                pick_prio;
  logic                                p_we, n_we, p_re, n_re;
  logic [tcwq_pkg::ID_W-1:0]           p_rdata, n_rdata;

  assign p_empty = (p_cnt_q == '0);
  assign n_empty = (n_cnt_q == '0);
  assign p_full  = (p_cnt_q == CNT_FULL);
  assign n_full  = (n_cnt_q == CNT_FULL);

  // Priority wins while the burst is open, or when nothing normal waits
  assign pick_prio = !p_empty && ((burst_q < burst_limit_i) || n_empty);

  assign cmd_ready_o = (state_q == ST_IDLE) && (!res_valid_q || res_pop_i);
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d     = state_q;
    src_prio_d  = src_prio_q;
    p_head_d    = p_head_q;
    p_tail_d    = p_tail_q;
    p_cnt_d     = p_cnt_q;
    n_head_d    = n_head_q;
    n_tail_d    = n_tail_q;
    n_cnt_d     = n_cnt_q;
    burst_d     = burst_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_d       = res_q;
    p_we        = 1'b0;
    n_we        = 1'b0;
    p_re        = 1'b0;
    n_re        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          res_d.status          = tcwq_pkg::STATUS_DONE;
          res_d.served_id       = '0;
          res_d.served_priority = 1'b0;
          if (cmd_i.op == tcwq_pkg::OP_ENQUEUE) begin
            res_valid_d = 1'b1;
            if (cmd_i.is_priority) begin
              if (p_full) begin
                res_d.status = tcwq_pkg::STATUS_FULL;
              end else begin
                p_we     = 1'b1;
                p_tail_d = ptr_next(p_tail_q);
                p_cnt_d  = p_cnt_q + 1'b1;
              end
            end else begin
              if (n_full) begin
                res_d.status = tcwq_pkg::STATUS_FULL;
              end else begin
                n_we     = 1'b1;
                n_tail_d = ptr_next(n_tail_q);
                n_cnt_d  = n_cnt_q + 1'b1;
              end
            end
          end else if (p_empty && n_empty) begin
            res_valid_d  = 1'b1;
            res_d.status = tcwq_pkg::STATUS_EMPTY;
          end else if (pick_prio) begin
            // Read the head into the RAM output register; ST_READ then loads the result register
            p_re       = 1'b1;
            p_head_d   = ptr_next(p_head_q);
            p_cnt_d    = p_cnt_q - 1'b1;
            src_prio_d = 1'b1;
            state_d    = ST_READ;
            if (burst_q < burst_limit_i) begin
              burst_d = burst_q + 1'b1;
            end
          end else begin
            n_re       = 1'b1;
            n_head_d   = ptr_next(n_head_q);
            n_cnt_d    = n_cnt_q - 1'b1;
            src_prio_d = 1'b0;
            burst_d    = '0;
            state_d    = ST_READ;
          end
        end
      end
      ST_READ: begin
        res_valid_d           = 1'b1;
        res_d.status          = tcwq_pkg::STATUS_DONE;
        res_d.served_id       = src_prio_q ? p_rdata : n_rdata;
        res_d.served_priority = src_prio_q;
        state_d               = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_prio_q  <= 1'b0;
      p_head_q    <= '0;
      p_tail_q    <= '0;
      p_cnt_q     <= '0;
      n_head_q    <= '0;
      n_tail_q    <= '0;
      n_cnt_q     <= '0;
      burst_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      src_prio_q  <= src_prio_d;
      p_head_q    <= p_head_d;
      p_tail_q    <= p_tail_d;
      p_cnt_q     <= p_cnt_d;
      n_head_q    <= n_head_d;
      n_tail_q    <= n_tail_d;
      n_cnt_q     <= n_cnt_d;
      burst_q     <= burst_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  tcwq_ram #(
    .WIDTH(tcwq_pkg::ID_W),
    .DEPTH(tcwq_pkg::QUEUE_DEPTH)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_tail_q),
    .wdata_i(cmd_i.entry_id),
    .re_i   (p_re),
    .raddr_i(p_head_q),
    .rdata_o(p_rdata)
  );

  tcwq_ram #(
    .WIDTH(tcwq_pkg::ID_W),
    .DEPTH(tcwq_pkg::QUEUE_DEPTH)
  ) u_norm_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_tail_q),
    .wdata_i(cmd_i.entry_id),
    .re_i   (n_re),
    .raddr_i(n_head_q),
    .rdata_o(n_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* design/two_class_weighted_queue_scheduler.sv */
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------
// input     | push / full            | op_i, entry_id_i, is_priority_i
// result    | pop / empty            | status_o, served_id_o, served_priority_o
// register  | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// An enqueue result passes the command queue, then the scheduler's result register, before it
// shows on the ports; a serve also passes the registered RAM read on its way.
// The scheduler takes one command per cycle, but holds off during the read cycle of a serve
// and while an unpopped result sits in its one-entry result register; the two-entry
// command queue then fills and raises full.
// Reset (rst_ni, asynchronous, active low) empties both FIFOs, clears the burst count and
// loads priority_burst with 2; RAM contents need no clearing.
module two_class_weighted_queue_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input queue side
  input  logic                               push,
  output logic                               full,
  input  logic                               op_i,
  input  logic [tcwq_pkg::ID_W-1:0]          entry_id_i,
  input  logic                               is_priority_i,
  // Result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         status_o,
  output logic [tcwq_pkg::ID_W-1:0]          served_id_o,
  output logic                               served_priority_o,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcwq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tcwq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tcwq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [tcwq_pkg::BURST_W-1:0]   burst_limit_q, burst_limit_d;
  logic [tcwq_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_wr;
  logic                           cmd_valid, cmd_ready;
  tcwq_pkg::cmd_t                 cmd;
  logic                           res_valid;
  tcwq_pkg::res_t                 res;

  // Register port: word index sits above the byte offset
  assign pready  = 1'b1;
  assign reg_idx = paddr[tcwq_pkg::APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    burst_limit_d = burst_limit_q;
    // Drop writes outside the register map
    if (reg_wr && (reg_idx == tcwq_pkg::REG_PRIORITY_BURST)) begin
      burst_limit_d = pwdata[tcwq_pkg::BURST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tcwq_pkg::REG_PRIORITY_BURST) begin
      prdata = tcwq_pkg::APB_DATA_W'(burst_limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_limit_q <= tcwq_pkg::BURST_RESET;
    end else begin
      burst_limit_q <= burst_limit_d;
    end
  end

  // Front: accept and classify items, buffer them as commands
  tcwq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .op_i         (op_i),
    .entry_id_i   (entry_id_i),
    .is_priority_i(is_priority_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // Back: the two FIFOs, the burst arbiter and the result register
  tcwq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_limit_i(burst_limit_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_o        (res)
  );

  assign empty             = !res_valid;
  assign status_o          = res.status;
  assign served_id_o       = res.served_id;
  assign served_priority_o = res.served_priority;

`ifndef SYNTHESIS
  // A result that is not a completed transfer carries no identifier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != tcwq_pkg::STATUS_DONE)) |-> (served_id_o == '0))
    else $error("served_id nonzero on a result that is not done");

  // Priority flag appears only on a completed serve
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && served_priority_o) |-> (status_o == tcwq_pkg::STATUS_DONE))
    else $error("served_priority set on a result that is not done");

  // A register write lands in the burst limit on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (reg_idx == tcwq_pkg::REG_PRIORITY_BURST))
      |=> (burst_limit_q == $past(pwdata[tcwq_pkg::BURST_W-1:0])))
    else $error("priority_burst write lost");
`endif

endmodule

/* tb/sv/two_class_weighted_queue_scheduler_tb.sv */
module two_class_weighted_queue_scheduler_tb;

  // Register map: one register per 32-bit word
  localparam logic [tcwq_pkg::APB_ADDR_W-1:0] BURST_ADDR  =
    {tcwq_pkg::REG_PRIORITY_BURST, 2'b00};
  localparam logic [tcwq_pkg::APB_ADDR_W-1:0] UNUSED_ADDR =
    {~tcwq_pkg::REG_PRIORITY_BURST, 2'b00};

  // Receiver stall patterns
  localparam int RX_FREE = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;

  // Cycles to let pass once nothing is awaited (serve path: RAM read and result registers plus queue)
  localparam int SETTLE_CYCLES = 8;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            push;
  logic                            full;
  logic                            op_i;
  logic [tcwq_pkg::ID_W-1:0]       entry_id_i;
  logic                            is_priority_i;
  logic                            empty;
  logic                            pop;
  logic [1:0]                      status_o;
  logic [tcwq_pkg::ID_W-1:0]       served_id_o;
  logic                            served_priority_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [tcwq_pkg::APB_ADDR_W-1:0] paddr;
  logic [tcwq_pkg::APB_DATA_W-1:0] pwdata;
  logic [tcwq_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  typedef struct {
    tcwq_pkg::status_e         status;
    logic [tcwq_pkg::ID_W-1:0] id;
    logic                      from_prio;
  } outcome_t;

  // Scheduler mirror: both FIFOs, the run of priority serves and its limit
  logic [tcwq_pkg::ID_W-1:0]    prio_fifo[$];
  logic [tcwq_pkg::ID_W-1:0]    norm_fifo[$];
  logic [tcwq_pkg::BURST_W-1:0] run_len = '0;
  logic [tcwq_pkg::BURST_W-1:0] burst_limit = tcwq_pkg::BURST_RESET;

  // Outcomes of accepted items, oldest first
  outcome_t due_outcomes[$];
  int       fault_count = 0;
  int       rx_mode = RX_FREE;

  two_class_weighted_queue_scheduler uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .op_i             (op_i),
    .entry_id_i       (entry_id_i),
    .is_priority_i    (is_priority_i),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .served_id_o      (served_id_o),
    .served_priority_o(served_priority_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk_i = ~clk_i;

  // Work out the outcome of one accepted item and advance the mirror.
  task automatic arbitrate_item(tcwq_pkg::op_e op, logic [tcwq_pkg::ID_W-1:0] id,
                                logic prio);
    outcome_t o;
    o.status    = tcwq_pkg::STATUS_DONE;
    o.id        = '0;
    o.from_prio = 1'b0;
    if (op == tcwq_pkg::OP_ENQUEUE) begin
      // Drop the entry when its target FIFO is full
      if (prio) begin
        if (prio_fifo.size() >= tcwq_pkg::QUEUE_DEPTH) o.status = tcwq_pkg::STATUS_FULL;
        else prio_fifo.push_back(id);
      end else begin
        if (norm_fifo.size() >= tcwq_pkg::QUEUE_DEPTH) o.status = tcwq_pkg::STATUS_FULL;
        else norm_fifo.push_back(id);
      end
    end else if (prio_fifo.size() == 0 && norm_fifo.size() == 0) begin
      // Nothing to serve: the run length holds
      o.status = tcwq_pkg::STATUS_EMPTY;
    end else if (prio_fifo.size() != 0 &&
                 (run_len < burst_limit || norm_fifo.size() == 0)) begin
      o.id        = prio_fifo.pop_front();
      o.from_prio = 1'b1;
      // Saturate the run at the limit
      if (run_len < burst_limit) run_len = run_len + 1'b1;
    end else begin
      o.id    = norm_fifo.pop_front();
      run_len = '0;
    end
    due_outcomes.push_back(o);
  endtask

  // Drive one item from a falling edge and hold it until the transfer.
  // Push stays high so the next item follows without a gap.
  task automatic send_item(tcwq_pkg::op_e op, logic [tcwq_pkg::ID_W-1:0] id, logic prio);
    push          = 1'b1;
    op_i          = op;
    entry_id_i    = id;
    is_priority_i = prio;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    arbitrate_item(op, id, prio);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int cycles);
    push = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Hold the sender until every awaited outcome has been transferred.
  task automatic wait_idle();
    push = 1'b0;
    while (due_outcomes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tcwq_pkg::APB_ADDR_W-1:0] addr,
                           logic [tcwq_pkg::APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == BURST_ADDR) burst_limit = data[tcwq_pkg::BURST_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read the burst register back and compare with the mirror.
  task automatic check_burst_reg();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = BURST_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[tcwq_pkg::BURST_W-1:0] !== burst_limit) begin
      $error("priority_burst: expected %0d, got %0d", burst_limit,
             prdata[tcwq_pkg::BURST_W-1:0]);
      fault_count++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Serve order under the reset limit of two, ID extremes, serve on empty.
  // Serves carry junk in entry_id and is_priority, which must be ignored.
  task automatic test_reset_order();
    send_item(tcwq_pkg::OP_SERVE, 16'hFFFF, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'hFFFF, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h0000, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'hAAAA, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h5555, 1'b0);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h0001, 1'b0);
    send_item(tcwq_pkg::OP_SERVE, 16'h0000, 1'b0);
    send_item(tcwq_pkg::OP_SERVE, 16'hFFFF, 1'b1);
    send_item(tcwq_pkg::OP_SERVE, 16'h1234, 1'b0);
    send_item(tcwq_pkg::OP_SERVE, 16'h0000, 1'b1);
    send_item(tcwq_pkg::OP_SERVE, 16'hFFFF, 1'b0);
    send_item(tcwq_pkg::OP_SERVE, 16'h0000, 1'b0);
    wait_idle();
  endtask

  // Limit of zero, ignored register index, full limit, limit lowered mid-run.
  task automatic test_burst_limits();
    check_burst_reg();
    write_reg(BURST_ADDR, 32'd0);
    check_burst_reg();
    // Limit zero: normal entries win while any remain
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h1234, 1'b0);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h4321, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h00FF, 1'b0);
    repeat (3) send_item(tcwq_pkg::OP_SERVE, 16'hFFFF, 1'b1);
    wait_idle();
    write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);
    check_burst_reg();
    // Only the low bits of the write land in the register
    write_reg(BURST_ADDR, 32'hABCD_EF0F);
    check_burst_reg();
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h8001, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h8002, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h8003, 1'b1);
    send_item(tcwq_pkg::OP_ENQUEUE, 16'h7FFE, 1'b0);
    repeat (3) send_item(tcwq_pkg::OP_SERVE, 16'h0000, 1'b0);
    wait_idle();
    // Drop the limit below the current run: the normal entry goes next
    write_reg(BURST_ADDR, 32'd1);
    check_burst_reg();
    send_item(tcwq_pkg::OP_SERVE, 16'h0000, 1'b0);
    wait_idle();
  endtask

  // One stretch of random traffic with a given enqueue and priority mix.
  task automatic run_traffic(int items, int enq_pct, int prio_pct, bit gaps);
    int                        burst_left;
    tcwq_pkg::op_e             op;
    logic [tcwq_pkg::ID_W-1:0] id;
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < items; k++) begin
      if (gaps && burst_left == 0) begin
        idle_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 16);
      end
      op = ($urandom_range(0, 99) < enq_pct) ? tcwq_pkg::OP_ENQUEUE : tcwq_pkg::OP_SERVE;
      case ($urandom_range(0, 15))
        0:       id = '0;
        1:       id = '1;
        default: id = tcwq_pkg::ID_W'($urandom_range(0, 65535));
      endcase
      send_item(op, id, $urandom_range(0, 99) < prio_pct);
      burst_left--;
    end
  endtask

  // Phases of fill, mixed and drain traffic under changing limits and stalls.
  task automatic test_random_traffic();
    logic [tcwq_pkg::BURST_W-1:0] limit;
    int                           prio_pct;
    bit                           gaps;
    for (int ph = 0; ph < 12; ph++) begin
      // Cover the extremes first, then random limits
      case (ph)
        0:       limit = 4'd1;
        1:       limit = 4'd15;
        2:       limit = 4'd0;
        3:       limit = tcwq_pkg::BURST_RESET;
        default: limit = tcwq_pkg::BURST_W'($urandom_range(0, 15));
      endcase
      wait_idle();
      write_reg(BURST_ADDR, {{(tcwq_pkg::APB_DATA_W-tcwq_pkg::BURST_W){1'b0}}, limit});
      if (ph % 4 == 0) check_burst_reg();
      rx_mode  = (ph % 3 == 0) ? RX_FREE : $urandom_range(RX_FREE, RX_SLOW);
      gaps     = (ph % 3 != 1);
      prio_pct = $urandom_range(10, 90);
      run_traffic(40, 85, prio_pct, gaps);
      run_traffic(50, 50, $urandom_range(10, 90), gaps);
      run_traffic(30, 20, prio_pct, gaps);
    end
  endtask

  // Receiver: stall on a pattern chosen per phase.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      case (rx_mode)
        RX_FREE: pop = 1'b1;
        RX_COIN: pop = $urandom_range(0, 1);
        default: pop = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare every transferred result with the oldest awaited outcome.
  always @(posedge clk_i) begin : check_result
    outcome_t want;
    if (rst_ni && pop && !empty) begin
      if (due_outcomes.size() == 0) begin
        $error("unexpected result: status %0d, served_id %h, served_priority %0d",
               status_o, served_id_o, served_priority_o);
        fault_count++;
      end else begin
        want = due_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fault_count++;
        end
        if (served_id_o !== want.id) begin
          $error("served_id: expected %h, got %h", want.id, served_id_o);
          fault_count++;
        end
        if (served_priority_o !== want.from_prio) begin
          $error("served_priority: expected %0d, got %0d", want.from_prio,
                 served_priority_o);
          fault_count++;
        end
      end
    end
  end

  // Drop the run if it hangs.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    op_i          = tcwq_pkg::OP_ENQUEUE;
    entry_id_i    = '0;
    is_priority_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_order();
    test_burst_limits();
    test_random_traffic();

    // Drain with the receiver free, then watch for stray results
    rx_mode = RX_FREE;
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (due_outcomes.size() != 0) begin
      $error("%0d results never arrived", due_outcomes.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
